// ===== rtl/epw_pkg.sv =====
package epw_pkg;

  localparam int TABLE_ROWS = 8;
  localparam int EPW_BAND_ENTRIES = 8;

  localparam int EARFCN_W = 16;
  localparam int IDX_W = 3;
  localparam int FREQ_W = 12;
  localparam int INT_W = 10;
  localparam int FRAC_W = 23;
  localparam int REF_W = 7;

  // offset from band start, at most 999
  localparam int DIFF_W = 10;
  // 4 * freq, at most 4 * 2619
  localparam int VCO_W = 14;
  // 2 * rem * scale + ref
  localparam int NUM_W = 31;
  // partial remainder against 2 * ref
  localparam int FREM_W = 8;

  localparam logic [FRAC_W-1:0] FRAC_SCALE = 23'd8388593;
  localparam logic [FRAC_W-1:0] FRAC_MAX_CODE = 23'd8388592;
  localparam logic [INT_W-1:0] INT_MAX_CODE = 10'd1023;

  localparam logic [REF_W-1:0] REF_MIN = 7'd10;
  localparam logic [REF_W-1:0] REF_MAX = 7'd100;
  localparam logic [REF_W-1:0] REF_RESET = 7'd40;

  // x / 10 == (x * 205) >> 11 for x below 1029
  localparam logic [7:0] DIV10_MUL = 8'd205;
  localparam int DIV10_SHIFT = 11;

  localparam logic [FREQ_W-1:0] BAND_FLOW [TABLE_ROWS] = '{
    12'd1900, 12'd2010, 12'd1850, 12'd1930, 12'd1910, 12'd2570, 12'd1880, 12'd2300
  };
  localparam logic [EARFCN_W-1:0] BAND_FIRST [TABLE_ROWS] = '{
    16'd36000, 16'd36200, 16'd36350, 16'd36950,
    16'd37550, 16'd37750, 16'd38250, 16'd38650
  };
  localparam logic [EARFCN_W-1:0] BAND_LAST [TABLE_ROWS] = '{
    16'd36199, 16'd36349, 16'd36949, 16'd37549,
    16'd37749, 16'd38249, 16'd38649, 16'd39649
  };

  // division steps done per pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int IDIV_STAGES = (VCO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int FDIV_STAGES = (FRAC_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam int ST_LOOK = 0;
  localparam int ST_FREQ = 1;
  localparam int ST_IDIV0 = 2;
  localparam int ST_FPREP = ST_IDIV0 + IDIV_STAGES;
  localparam int ST_FDIV0 = ST_FPREP + 1;
  localparam int PIPE_STAGES = ST_FDIV0 + FDIV_STAGES;

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      idx;
    logic [FREQ_W-1:0]     fbase;
    logic [DIFF_W-1:0]     diff;
    logic [FREQ_W-1:0]     freq;
    logic [VCO_W-1:0]      inum;
    logic [REF_W-1:0]      irem;
    logic [VCO_W-1:0]      quo;
    logic [FRAC_W-1:0]     fnum;
    logic [FREM_W-1:0]     frem;
    logic [FRAC_W-1:0]     fq;
  } item_t;

  // one restoring step of 4*freq / ref
  function automatic item_t idiv_step(item_t x, logic [REF_W-1:0] r);
    item_t y;
    logic [REF_W:0] t;
    y = x;
    t = {x.irem, x.inum[VCO_W-1]};
    y.inum = {x.inum[VCO_W-2:0], 1'b0};
    if (t >= {1'b0, r}) begin
      y.irem = REF_W'(t - {1'b0, r});
      y.quo = {x.quo[VCO_W-2:0], 1'b1};
    end else begin
      y.irem = t[REF_W-1:0];
      y.quo = {x.quo[VCO_W-2:0], 1'b0};
    end
    return y;
  endfunction

  // one restoring step of the fraction numerator / (2 * ref)
  function automatic item_t fdiv_step(item_t x, logic [REF_W-1:0] r);
    item_t y;
    logic [FREM_W:0] t;
    logic [FREM_W:0] d;
    y = x;
    t = {x.frem, x.fnum[FRAC_W-1]};
    d = {1'b0, r, 1'b0};
    y.fnum = {x.fnum[FRAC_W-2:0], 1'b0};
    if (t >= d) begin
      y.frem = FREM_W'(t - d);
      y.fq = {x.fq[FRAC_W-2:0], 1'b1};
    end else begin
      y.frem = t[FREM_W-1:0];
      y.fq = {x.fq[FRAC_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

// ===== rtl/earfcn_to_pll_word_top.sv =====
// EARFCN to fractional-N PLL word converter.
// Input channel: earfcn with in_valid / in_stall; a transfer happens on a clock
// edge with in_valid high and in_stall low. Output channel: found, band_index,
// freq_mhz, pll_int, pll_frac with out_valid / out_stall, same rule.
// Each input transfer yields exactly one result. Channel numbers outside the
// TDD band table give found = 0 and all other fields 0.
// Throughput: one item per cycle while the receiver does not stall; the
// depth is set by the two restoring dividers (four quotient bits per stage),
// one for the integer word and one for the fraction.
// ref_clock_mhz is written when ref_clock_mhz_we is high, clamped to
// 10..100 on the write; write it only while the pipeline is empty.
// Reset (rst, synchronous) empties the pipeline and sets the reference clock
// to 40 MHz. When the receiver stalls, the output register holds its result;
// upstream stages keep filling bubbles and in_stall rises only once every
// stage holds an item.
module earfcn_to_pll_word_top #(
  parameter int BAND_ENTRIES = epw_pkg::EPW_BAND_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ref_clock_mhz_we,
  input  logic [epw_pkg::REF_W-1:0]       ref_clock_mhz,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [epw_pkg::EARFCN_W-1:0]    earfcn,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [epw_pkg::IDX_W-1:0]       band_index,
  output logic [epw_pkg::FREQ_W-1:0]      freq_mhz,
  output logic [epw_pkg::INT_W-1:0]       pll_int,
  output logic [epw_pkg::FRAC_W-1:0]      pll_frac
);
  import epw_pkg::*;

  localparam int SCAN_ROWS = (BAND_ENTRIES < TABLE_ROWS) ? BAND_ENTRIES : TABLE_ROWS;

  logic [REF_W-1:0] rclk;

  item_t pipe [PIPE_STAGES];
  item_t nxt [PIPE_STAGES];
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES:0] rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rclk <= REF_RESET;
    end else if (ref_clock_mhz_we) begin
      if (ref_clock_mhz < REF_MIN) begin
        rclk <= REF_MIN;
      end else if (ref_clock_mhz > REF_MAX) begin
        rclk <= REF_MAX;
      end else begin
        rclk <= ref_clock_mhz;
      end
    end
  end

  // a stage takes a new item when empty or when its item moves on
  always_comb begin
    rdy[PIPE_STAGES] = !out_valid || !out_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end
  assign in_stall = !rdy[0];

  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stage
    if (k == ST_LOOK) begin : g_look
      always_comb begin
        item_t y;
        y = '0;
        // scan downward so the first matching row wins
        for (int i = SCAN_ROWS - 1; i >= 0; i--) begin
          if (earfcn >= BAND_FIRST[i] && earfcn <= BAND_LAST[i]) begin
            y.hit = 1'b1;
            y.idx = IDX_W'(i);
            y.fbase = BAND_FLOW[i];
            y.diff = DIFF_W'(earfcn - BAND_FIRST[i]);
          end
        end
        nxt[k] = y;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= in_valid;
        end
      end
    end else begin : g_work
      always_comb begin
        item_t y;
        logic [DIFF_W+7:0] prod10;
        logic [29:0] prodf;
        logic [NUM_W-1:0] num;
        y = pipe[k-1];
        prod10 = '0;
        prodf = '0;
        num = '0;
        if (k == ST_FREQ) begin
          prod10 = 18'(y.diff) * 18'(DIV10_MUL);
          y.freq = y.fbase + FREQ_W'(prod10[DIV10_SHIFT +: 7]);
          y.inum = {y.freq, 2'b00};
          y.irem = '0;
          y.quo = '0;
        end else if (k < ST_FPREP) begin
          for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if ((k - ST_IDIV0) * STEPS_PER_STAGE + j < VCO_W) begin
              y = idiv_step(y, rclk);
            end
          end
        end else if (k == ST_FPREP) begin
          prodf = 30'(y.irem) * 30'(FRAC_SCALE);
          num = {prodf, 1'b0} + NUM_W'(rclk);
          y.frem = num[NUM_W-1 -: FREM_W];
          y.fnum = num[FRAC_W-1:0];
          y.fq = '0;
        end else begin
          for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if ((k - ST_FDIV0) * STEPS_PER_STAGE + j < FRAC_W) begin
              y = fdiv_step(y, rclk);
            end
          end
        end
        nxt[k] = y;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[PIPE_STAGES]) begin
      out_valid <= vld[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[PIPE_STAGES]) begin
      found <= pipe[PIPE_STAGES-1].hit;
      if (pipe[PIPE_STAGES-1].hit) begin
        band_index <= pipe[PIPE_STAGES-1].idx;
        freq_mhz <= pipe[PIPE_STAGES-1].freq;
        // integer word saturates, only reachable in the highest band
        if (pipe[PIPE_STAGES-1].quo[VCO_W-1:INT_W] != '0) begin
          pll_int <= INT_MAX_CODE;
          pll_frac <= FRAC_MAX_CODE;
        end else begin
          pll_int <= pipe[PIPE_STAGES-1].quo[INT_W-1:0];
          pll_frac <= pipe[PIPE_STAGES-1].fq;
        end
      end else begin
        band_index <= '0;
        freq_mhz <= '0;
        pll_int <= '0;
        pll_frac <= '0;
      end
    end
  end

endmodule
